// File: src/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg: shared definitions of the sequence reorder buffer
// Field widths, the serial-comparison half range, the default window size,
// and the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int SEQ_W                = 16;
    localparam int HANDLE_W             = 32;
    localparam int HALF_RANGE           = 32768;
    localparam int DEFAULT_WINDOW_SLOTS = 256;

    // Commands issued by the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the incoming request
        logic clr_step;    // clear one slot of the reset sweep
        logic recv_exec;   // evaluate and store a received frame
        logic pop_read;    // read the head slot
        logic pop_finish;  // deliver the head slot and advance
    } cmd_t;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic is_pop;      // latched request is a pop
        logic clr_done;    // sweep is on its last slot
    } status_t;

endpackage

// File: src/srb_ctrl.sv
// ----------------------------------------------------------------------------
// srb_ctrl: sequencing controller of the sequence reorder buffer
// Runs the slot clearing sweep after reset and steps each request through
// its execute phases.
// ----------------------------------------------------------------------------
module srb_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  srb_pkg::status_t  status,
    output srb_pkg::cmd_t     cmd,
    output logic              busy
);

    localparam logic [1:0] ST_CLEAR    = 2'd0;
    localparam logic [1:0] ST_IDLE     = 2'd1;
    localparam logic [1:0] ST_EXEC     = 2'd2;
    localparam logic [1:0] ST_POP_WAIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.is_pop)
                begin
                    cmd.pop_read = 1'b1;
                    state_next   = ST_POP_WAIT;
                end
                else
                begin
                    cmd.recv_exec = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_POP_WAIT:
            begin
                cmd.pop_finish = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: src/srb_datapath.sv
// ----------------------------------------------------------------------------
// srb_datapath: slot memory and sequence arithmetic of the reorder buffer
// Holds the delivered pointer, the head slot index, the slot memory with a
// valid bit per entry, and the result registers.
// ----------------------------------------------------------------------------
module srb_datapath
#(
    parameter int WINDOW_SLOTS = srb_pkg::DEFAULT_WINDOW_SLOTS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  srb_pkg::cmd_t                 cmd,
    output srb_pkg::status_t              status,
    input  logic                          req_type,
    input  logic [srb_pkg::SEQ_W-1:0]     seq,
    input  logic [srb_pkg::HANDLE_W-1:0]  payload_handle,
    output logic                          done,
    output logic                          ack_valid,
    output logic [srb_pkg::SEQ_W-1:0]     ack_seq,
    output logic                          stored,
    output logic                          window_overflow,
    output logic                          pop_valid,
    output logic [srb_pkg::HANDLE_W-1:0]  pop_handle
);

    localparam int              IDX_W    = $clog2(WINDOW_SLOTS);
    localparam int              SEQ_W    = srb_pkg::SEQ_W;
    localparam int              HANDLE_W = srb_pkg::HANDLE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(WINDOW_SLOTS);
    localparam logic [SEQ_W:0]   SLOTS_D  = (SEQ_W + 1)'(WINDOW_SLOTS);
    localparam logic [SEQ_W-1:0] HALF     = SEQ_W'(srb_pkg::HALF_RANGE);

    // Request latch.
    logic                 is_pop_reg;
    logic [SEQ_W-1:0]     seq_in_reg;
    logic [HANDLE_W-1:0]  handle_in_reg;

    // Control state.
    logic [SEQ_W-1:0]     last_reg;
    logic [SEQ_W-1:0]     last_next;
    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     head_next;
    logic [IDX_W-1:0]     clr_cnt_reg;
    logic                 done_reg;

    // Slot memory: valid bit on top of the handle.
    logic [HANDLE_W:0]    slot_mem [WINDOW_SLOTS];
    logic [HANDLE_W:0]    rd_data_reg;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [HANDLE_W:0]    wr_data;

    // Result registers.
    logic                 ack_valid_reg;
    logic [SEQ_W-1:0]     ack_seq_reg;
    logic                 stored_reg;
    logic                 overflow_reg;
    logic                 pop_valid_reg;
    logic [HANDLE_W-1:0]  pop_handle_reg;

    // Receive evaluation.
    logic [SEQ_W-1:0]     fwd_dist;
    logic [SEQ_W-1:0]     dist_m1;
    logic                 newer;
    logic                 in_window;
    logic                 store_hit;
    logic [IDX_W:0]       idx_sum;
    logic [IDX_W-1:0]     recv_idx;
    logic                 head_valid;

    assign fwd_dist  = seq_in_reg - last_reg;
    assign dist_m1   = fwd_dist - SEQ_W'(1);
    assign newer     = (fwd_dist != '0) &&
                       (!fwd_dist[SEQ_W-1] ||
                        ((fwd_dist == HALF) && (seq_in_reg > last_reg)));
    assign in_window = ({1'b0, fwd_dist} <= SLOTS_D);
    assign store_hit = newer && in_window;

    // head plus offset stays below twice the window, so one subtract wraps it.
    assign idx_sum  = {1'b0, head_reg} + {1'b0, dist_m1[IDX_W-1:0]};
    assign recv_idx = (idx_sum >= SLOTS_X) ? IDX_W'(idx_sum - SLOTS_X) : idx_sum[IDX_W-1:0];

    assign head_valid = rd_data_reg[HANDLE_W];
    assign head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
    assign last_next  = last_reg + SEQ_W'(1);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = '0;
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
        end
        else if (cmd.recv_exec && store_hit)
        begin
            wr_en   = 1'b1;
            wr_addr = recv_idx;
            wr_data = {1'b1, handle_in_reg};
        end
        else if (cmd.pop_finish && head_valid)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (cmd.pop_read)
        begin
            rd_data_reg <= slot_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            seq_in_reg    <= seq;
            handle_in_reg <= payload_handle;
        end
        if (cmd.recv_exec)
        begin
            ack_valid_reg  <= 1'b1;
            ack_seq_reg    <= seq_in_reg;
            stored_reg     <= store_hit;
            overflow_reg   <= newer && !in_window;
            pop_valid_reg  <= 1'b0;
            pop_handle_reg <= '0;
        end
        else if (cmd.pop_finish)
        begin
            ack_valid_reg  <= 1'b0;
            ack_seq_reg    <= '0;
            stored_reg     <= 1'b0;
            overflow_reg   <= 1'b0;
            pop_valid_reg  <= head_valid;
            pop_handle_reg <= head_valid ? rd_data_reg[HANDLE_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_pop_reg  <= 1'b0;
            last_reg    <= '0;
            head_reg    <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.recv_exec | cmd.pop_finish;
            if (cmd.capture)
            begin
                is_pop_reg <= req_type;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= (clr_cnt_reg == LAST_IDX) ? '0 : clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.pop_finish && head_valid)
            begin
                last_reg <= last_next;
                head_reg <= head_next;
            end
        end
    end

    assign status.is_pop   = is_pop_reg;
    assign status.clr_done = (clr_cnt_reg == LAST_IDX);

    assign done            = done_reg;
    assign ack_valid       = ack_valid_reg;
    assign ack_seq         = ack_seq_reg;
    assign stored          = stored_reg;
    assign window_overflow = overflow_reg;
    assign pop_valid       = pop_valid_reg;
    assign pop_handle      = pop_handle_reg;

endmodule

// File: src/sequence_reorder_buffer.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer: receive-side reorder buffer of a reliable link
// Acknowledges received frames, keeps those inside the window ahead of the
// last delivered sequence number, and hands them out in order on pop.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The result of a
// receive request (req_type 0) is registered at the end of the EXEC state, and
// that of a pop request (req_type 1) in the POP_WAIT state that follows EXEC, the
// extra state being the registered read of the slot memory. The block takes
// one request at a time: busy is high from the cycle after a request is taken
// until its result is on the ports, and drops in that cycle, so the next
// request can be taken at the edge that ends the result. The result appears
// on the result ports for exactly one cycle with done high, and the receiver
// cannot stall it, so it must capture the result in that cycle. After reset
// the block sweeps the slot memory clear, one slot per cycle, and holds busy
// high until every slot is clear, before the first request can be taken. A
// received frame is always acknowledged with its own sequence number. It is
// stored only when it is newer than the last delivered sequence number in
// 16-bit serial arithmetic and lies no more than WINDOW_SLOTS ahead of it; a
// newer frame past the window is dropped and flagged with window_overflow.
// A pop delivers the frame right after the last delivered one if it is held,
// then frees its slot and advances the delivered pointer.
module sequence_reorder_buffer
#(
    parameter int WINDOW_SLOTS = srb_pkg::DEFAULT_WINDOW_SLOTS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [srb_pkg::SEQ_W-1:0]     seq,
    input  logic [srb_pkg::HANDLE_W-1:0]  payload_handle,
    output logic                          done,
    output logic                          ack_valid,
    output logic [srb_pkg::SEQ_W-1:0]     ack_seq,
    output logic                          stored,
    output logic                          window_overflow,
    output logic                          pop_valid,
    output logic [srb_pkg::HANDLE_W-1:0]  pop_handle
);

    // Command and status bundles between the sequencer and the datapath.
    srb_pkg::cmd_t    cmd;
    srb_pkg::status_t status;

    // The controller owns sequencing only; every state bit of the reorder
    // logic lives in the datapath.
    srb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    srb_datapath
    #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_type        (req_type),
        .seq             (seq),
        .payload_handle  (payload_handle),
        .done            (done),
        .ack_valid       (ack_valid),
        .ack_seq         (ack_seq),
        .stored          (stored),
        .window_overflow (window_overflow),
        .pop_valid       (pop_valid),
        .pop_handle      (pop_handle)
    );

`ifndef SYNTHESIS
    // A result only follows a request that was in progress.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // A taken request keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // A result is either a receive or a pop, never both.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !(ack_valid && pop_valid))
        else $error("result marks both a receive and a pop");

    // A frame is either stored or dropped past the window, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(stored && window_overflow))
        else $error("frame both stored and flagged as overflow");
`endif

endmodule

// File: test/srb_checker.sv
// ----------------------------------------------------------------------------
// srb_checker: result predictor and comparator for the sequence reorder buffer
// Watches the request and result channels of the block. It keeps its own view
// of the delivered pointer and the slot store, and checks every result
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
package srb_tb_pkg;

    typedef enum logic {
        REQ_RECEIVE = 1'b0,
        REQ_POP     = 1'b1
    } req_kind_e;

endpackage

module srb_checker
#(
    parameter int WINDOW_SLOTS = srb_pkg::DEFAULT_WINDOW_SLOTS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          req_type,
    input  logic [srb_pkg::SEQ_W-1:0]     seq,
    input  logic [srb_pkg::HANDLE_W-1:0]  payload_handle,
    input  logic                          done,
    input  logic                          ack_valid,
    input  logic [srb_pkg::SEQ_W-1:0]     ack_seq,
    input  logic                          stored,
    input  logic                          window_overflow,
    input  logic                          pop_valid,
    input  logic [srb_pkg::HANDLE_W-1:0]  pop_handle,
    output int unsigned                   pending,
    output int unsigned                   mismatches
);

    localparam int SEQ_W      = srb_pkg::SEQ_W;
    localparam int HANDLE_W   = srb_pkg::HANDLE_W;
    localparam int HALF_RANGE = srb_pkg::HALF_RANGE;
    localparam int FIFO_DEPTH = 8;

    typedef struct packed {
        logic                ack_valid;
        logic [SEQ_W-1:0]    ack_seq;
        logic                stored;
        logic                window_overflow;
        logic                pop_valid;
        logic [HANDLE_W-1:0] pop_handle;
    } frame_result_t;

    logic [SEQ_W-1:0]    delivered_seq;
    int unsigned         head_slot;
    logic                slot_held [WINDOW_SLOTS];
    logic [HANDLE_W-1:0] slot_data [WINDOW_SLOTS];
    frame_result_t       expected_fifo [FIFO_DEPTH];
    int unsigned         fifo_wr_idx;
    int unsigned         fifo_rd_idx;
    int unsigned         fifo_count;
    int unsigned         failures;

    // Applies one request to the local view of the buffer and returns the
    // result it must produce.
    function automatic frame_result_t reorder_predict(srb_tb_pkg::req_kind_e kind,
                                                      logic [SEQ_W-1:0] s,
                                                      logic [HANDLE_W-1:0] h);
        frame_result_t    r;
        logic [SEQ_W-1:0] fwd_dist;
        logic             newer;
        int unsigned      idx;
        r = '0;
        if (kind == srb_tb_pkg::REQ_RECEIVE)
        begin
            r.ack_valid = 1'b1;
            r.ack_seq   = s;
            fwd_dist = s - delivered_seq;
            newer = (fwd_dist != 0) &&
                    ((fwd_dist < HALF_RANGE) ||
                     (fwd_dist == HALF_RANGE && s > delivered_seq));
            if (newer)
            begin
                if (fwd_dist <= WINDOW_SLOTS)
                begin
                    idx = (head_slot + fwd_dist - 1) % WINDOW_SLOTS;
                    slot_held[idx] = 1'b1;
                    slot_data[idx] = h;
                    r.stored = 1'b1;
                end
                else
                begin
                    r.window_overflow = 1'b1;
                end
            end
        end
        else if (slot_held[head_slot])
        begin
            r.pop_valid  = 1'b1;
            r.pop_handle = slot_data[head_slot];
            slot_held[head_slot] = 1'b0;
            delivered_seq = delivered_seq + 1'b1;
            head_slot = (head_slot + 1) % WINDOW_SLOTS;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t got;
        frame_result_t want;
        frame_result_t predicted;
        if (!rst_n)
        begin
            delivered_seq = '0;
            head_slot     = 0;
            foreach (slot_held[i])
            begin
                slot_held[i] = 1'b0;
            end
            fifo_wr_idx = 0;
            fifo_rd_idx = 0;
            fifo_count  = 0;
            failures = 0;
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            // The result leaving at this edge belongs to an older request
            // than any accepted at the same edge, so compare first.
            if (done)
            begin
                got = {ack_valid, ack_seq, stored, window_overflow, pop_valid, pop_handle};
                if (fifo_count == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: result with no request outstanding: ack=%0b seq=%0d",
                                 $realtime, got.ack_valid, got.ack_seq);
                end
                else
                begin
                    want = expected_fifo[fifo_rd_idx];
                    fifo_rd_idx = (fifo_rd_idx + 1) % FIFO_DEPTH;
                    fifo_count--;
                    if (got !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"%0t: mismatch expected ack=%0b seq=%0d stored=%0b",
                                      " ovf=%0b pop=%0b handle=%h, got ack=%0b seq=%0d",
                                      " stored=%0b ovf=%0b pop=%0b handle=%h"}, $realtime,
                                     want.ack_valid, want.ack_seq, want.stored,
                                     want.window_overflow, want.pop_valid, want.pop_handle,
                                     got.ack_valid, got.ack_seq, got.stored,
                                     got.window_overflow, got.pop_valid, got.pop_handle);
                    end
                end
            end
            if (start && !busy)
            begin
                predicted = reorder_predict(srb_tb_pkg::req_kind_e'(req_type), seq,
                                            payload_handle);
                if (fifo_count == FIFO_DEPTH)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: too many requests outstanding", $realtime);
                end
                else
                begin
                    expected_fifo[fifo_wr_idx] = predicted;
                    fifo_wr_idx = (fifo_wr_idx + 1) % FIFO_DEPTH;
                    fifo_count++;
                end
            end
            pending    <= fifo_count;
            mismatches <= failures;
        end
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: request-level test of the sequence reorder buffer
// Drives receive and pop requests through the start/busy handshake with
// random idle gaps, while a separate checker predicts and compares every
// result. A directed opening covers the window edges, stale frames and the
// serial-comparison half range; random traffic follows, and full-window runs,
// one in order and one reversed, walk the head slot all the way round.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SEQ_W        = srb_pkg::SEQ_W;
    localparam int HANDLE_W     = srb_pkg::HANDLE_W;
    localparam int HALF_RANGE   = srb_pkg::HALF_RANGE;
    localparam int WINDOW       = srb_pkg::DEFAULT_WINDOW_SLOTS;
    // The clearing sweep after reset is the longest legal silence.
    localparam int IDLE_LIMIT   = 4 * WINDOW + 1000;
    localparam int RANDOM_ITEMS = 325;
    // Two full windows: the first in order, the second reversed.
    localparam int BULK_BLOCKS  = 2;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                req_type = 1'b0;
    logic [SEQ_W-1:0]    seq = '0;
    logic [HANDLE_W-1:0] payload_handle = '0;
    logic                done;
    logic                ack_valid;
    logic [SEQ_W-1:0]    ack_seq;
    logic                stored;
    logic                window_overflow;
    logic                pop_valid;
    logic [HANDLE_W-1:0] pop_handle;

    int unsigned         pending;
    int unsigned         mismatches;
    int unsigned         idle_cycles = 0;
    logic [SEQ_W-1:0]    seen_delivered;   // delivered pointer as seen on the pop results
    logic                no_idle = 1'b0;   // when set, requests follow back to back

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sequence_reorder_buffer #(
        .WINDOW_SLOTS    (WINDOW)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .seq             (seq),
        .payload_handle  (payload_handle),
        .done            (done),
        .ack_valid       (ack_valid),
        .ack_seq         (ack_seq),
        .stored          (stored),
        .window_overflow (window_overflow),
        .pop_valid       (pop_valid),
        .pop_handle      (pop_handle)
    );

    srb_checker #(
        .WINDOW_SLOTS    (WINDOW)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .seq             (seq),
        .payload_handle  (payload_handle),
        .done            (done),
        .ack_valid       (ack_valid),
        .ack_seq         (ack_seq),
        .stored          (stored),
        .window_overflow (window_overflow),
        .pop_valid       (pop_valid),
        .pop_handle      (pop_handle),
        .pending         (pending),
        .mismatches      (mismatches)
    );

    // The stimulus aims its sequence numbers relative to the delivered
    // pointer. It follows the pop results, which may lag by a request or two;
    // that only shifts the aim and never affects checking.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_delivered <= '0;
        else if (done && pop_valid)
            seen_delivered <= seen_delivered + 1'b1;
    end

    // Watchdog: ends the run when neither a request nor a result has moved
    // for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Presents one request after a random idle gap and returns at the edge
    // where the block takes it. Start is left high, so a following request
    // with no gap goes out back to back.
    task automatic issue(input srb_tb_pkg::req_kind_e kind, input logic [SEQ_W-1:0] s,
                         input logic [HANDLE_W-1:0] h);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        req_type       <= kind;
        seq            <= s;
        payload_handle <= h;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Holds the request channel quiet until every predicted result is in.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Random traffic. Most receives land just ahead of the delivered pointer
    // so that pops keep finding frames; the rest spread over the window, its
    // edges, stale numbers and the whole sequence space.
    task automatic random_traffic(input int unsigned count);
        int unsigned      pick;
        logic [SEQ_W-1:0] s;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 32 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                s = SEQ_W'(seen_delivered + $urandom_range(1, 12));
            else if (pick < 50)
                s = SEQ_W'(seen_delivered + $urandom_range(1, WINDOW));
            else if (pick < 54)
            begin
                case ($urandom_range(0, 3))
                    0:       s = SEQ_W'(seen_delivered + WINDOW);
                    1:       s = SEQ_W'(seen_delivered + WINDOW + 1);
                    2:       s = SEQ_W'(seen_delivered + HALF_RANGE);
                    default: s = SEQ_W'(seen_delivered + HALF_RANGE - 1);
                endcase
            end
            else if (pick < 59)
                s = SEQ_W'($urandom);
            else if (pick < 63)
                s = SEQ_W'(seen_delivered - $urandom_range(0, 40));
            else
                s = SEQ_W'($urandom);
            if (pick < 63)
                issue(srb_tb_pkg::REQ_RECEIVE, s, $urandom);
            else
                issue(srb_tb_pkg::REQ_POP, s, $urandom);
        end
        no_idle = 1'b0;
    endtask

    // Fills the whole window and empties it in order, block after block,
    // which walks the head slot all the way round.
    task automatic advance_full_windows();
        logic [SEQ_W-1:0] base;
        base = seen_delivered;
        for (int unsigned blk = 0; blk < BULK_BLOCKS; blk++)
        begin
            no_idle = ($urandom_range(0, 1) == 1);
            for (int unsigned k = 1; k <= WINDOW; k++)
            begin
                // Odd blocks arrive in reverse order to exercise reordering.
                if (blk % 2 == 1)
                    issue(srb_tb_pkg::REQ_RECEIVE, SEQ_W'(base + WINDOW + 1 - k), $urandom);
                else
                    issue(srb_tb_pkg::REQ_RECEIVE, SEQ_W'(base + k), $urandom);
            end
            for (int unsigned k = 0; k < WINDOW; k++)
                issue(srb_tb_pkg::REQ_POP, SEQ_W'($urandom), $urandom);
            base = SEQ_W'(base + WINDOW);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        logic [SEQ_W-1:0] base;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening, starting from an empty buffer with the delivered
        // pointer at zero.
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd0, 32'h0000_0000);     // same as delivered: stale
        issue(srb_tb_pkg::REQ_POP, 16'hFFFF, 32'hFFFF_FFFF);      // pop with nothing held
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd1, 32'hFFFF_FFFF);     // next in order
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd1, 32'h1234_5678);     // newer copy overwrites
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd256, 32'hA5A5_A5A5);   // last slot of the window
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd257, 32'h5A5A_5A5A);   // one past the window
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd32767, 32'h0F0F_0F0F); // far ahead, still newer
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd32768, 32'hF0F0_F0F0); // half range, greater
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd32769, 32'h0000_0001); // just behind by serial rule
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd65535, 32'h8000_0000); // one behind, wrapped
        issue(srb_tb_pkg::REQ_POP, 16'd0, 32'h0000_0000);         // delivers the overwriting copy
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd1, 32'h0000_0002);     // already delivered
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd0, 32'h0000_0003);     // older still
        issue(srb_tb_pkg::REQ_POP, 16'd0, 32'h0000_0000);         // gap in order: nothing
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd2, 32'h0000_0000);
        issue(srb_tb_pkg::REQ_POP, 16'd0, 32'h0000_0000);
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd257, 32'hDEAD_0001);   // now inside, head slot moved
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd258, 32'hDEAD_0002);   // window edge after advancing
        issue(srb_tb_pkg::REQ_RECEIVE, 16'd259, 32'hDEAD_0003);   // past the edge again
        issue(srb_tb_pkg::REQ_POP, 16'd0, 32'h0000_0000);

        random_traffic(RANDOM_ITEMS);

        // Let everything settle, so the delivered pointer is known exactly.
        drain();
        advance_full_windows();
        drain();

        // Probes around the half range and the window edge, aimed at a
        // delivered pointer that is known exactly.
        base = seen_delivered;
        issue(srb_tb_pkg::REQ_RECEIVE, SEQ_W'(base - HALF_RANGE), $urandom);
        issue(srb_tb_pkg::REQ_RECEIVE, SEQ_W'(base + HALF_RANGE - 1), $urandom);
        issue(srb_tb_pkg::REQ_RECEIVE, SEQ_W'(base + 1), $urandom);
        issue(srb_tb_pkg::REQ_RECEIVE, SEQ_W'(base + WINDOW), $urandom);
        issue(srb_tb_pkg::REQ_POP, SEQ_W'($urandom), $urandom);

        random_traffic(RANDOM_ITEMS);

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
src/srb_pkg.sv
src/srb_ctrl.sv
src/srb_datapath.sv
src/sequence_reorder_buffer.sv
test/srb_checker.sv
test/testbench.sv
